// ----- rtl/tcce_pkg.sv -----
// shared types, constants and codes of the text console character engine
// no dependencies; imported by every module of the engine but tcce_ram

package tcce_pkg;

   // screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int MOVE_COUNT = (ROWS - 1) * COLUMNS;

   localparam int ADDR_W = $clog2(CELL_COUNT);
   localparam int LIN_W  = $clog2(CELL_COUNT + 1);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLUMNS + 1);

   // field widths of the transactions
   localparam int CMD_W  = 2;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int POS_W  = 11;
   localparam int CELL_W = ATTR_W + CHAR_W;

   // small queues, depth a power of two
   localparam int CQ_DEPTH = 2;
   localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
   localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);
   localparam int RQ_DEPTH = 2;
   localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
   localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

   // command codes
   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_LEFT      = 8'h01;
   localparam logic [CHAR_W-1:0] CHAR_RIGHT     = 8'h02;
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'h20;

   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [CHAR_W-1:0] char_code;
      logic [10:0]       cell_addr;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]  cursor_pos;
      logic [CELL_W-1:0] cell_data;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_LEFT,
      OP_RIGHT,
      OP_NEWLINE,
      OP_BACKSPACE,
      OP_GLYPH,
      OP_CLEAR,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [CHAR_W-1:0] char_code;
      logic [10:0]       cell_addr;
   } work_type;

   // back end to front end
   typedef struct packed {
      logic take;
      logic busy;
   } back_ctrl_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_SCROLL,
      ST_GLYPH,
      ST_DONE
   } state_type;

endpackage

// ----- rtl/tcce_ram.sv -----
// generic single write port, single read port ram with registered read data
// no dependencies

module tcce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/tcce_front.sv -----
// front end: accepts request transactions, classifies them, holds them in a short queue
// depends on tcce_pkg

module tcce_front
   import tcce_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   input  req_type       req_data,
   output logic          req_full,
   input  back_ctrl_type ctrl,
   output logic          work_valid,
   output work_type      work
);

   work_type             q_ff [CQ_DEPTH];
   logic [CQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CQ_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CQ_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                 push_ok;
   work_type             entry;

   // classify
   always_comb begin
      entry.char_code = req_data.char_code;
      entry.cell_addr = req_data.cell_addr;
      case (req_data.cmd)
         CMD_PUT: begin
            case (req_data.char_code)
               CHAR_LEFT:      entry.op = OP_LEFT;
               CHAR_RIGHT:     entry.op = OP_RIGHT;
               CHAR_NEWLINE:   entry.op = OP_NEWLINE;
               CHAR_BACKSPACE: entry.op = OP_BACKSPACE;
               default:        entry.op = OP_GLYPH;
            endcase
         end
         CMD_CLEAR: entry.op = OP_CLEAR;
         CMD_READ:  entry.op = OP_READ;
         default:   entry.op = OP_NOP;
      endcase
   end

   assign req_full   = (cnt_ff == CQ_CNT_W'(CQ_DEPTH)) || ctrl.busy;
   assign push_ok    = req_push && !req_full;
   assign work_valid = (cnt_ff != '0);
   assign work       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok   ? wr_ptr_ff + CQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = ctrl.take ? rd_ptr_ff + CQ_PTR_W'(1) : rd_ptr_ff;
      case ({push_ok, ctrl.take})
         2'b10:   cnt_in = cnt_ff + CQ_CNT_W'(1);
         2'b01:   cnt_in = cnt_ff - CQ_CNT_W'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

// ----- rtl/tcce_rsp_fifo.sv -----
// result queue: holds finished results until the consumer pops them
// depends on tcce_pkg

module tcce_rsp_fifo
   import tcce_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   rsp_type              q_ff [RQ_DEPTH];
   logic [RQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [RQ_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [RQ_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                 push_ok;
   logic                 pop_ok;

   assign full      = (cnt_ff == RQ_CNT_W'(RQ_DEPTH));
   assign rsp_empty = (cnt_ff == '0);
   assign push_ok   = push && !full;
   assign pop_ok    = rsp_pop && !rsp_empty;
   assign rsp_data  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + RQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_ok  ? rd_ptr_ff + RQ_PTR_W'(1) : rd_ptr_ff;
      case ({push_ok, pop_ok})
         2'b10:   cnt_in = cnt_ff + RQ_CNT_W'(1);
         2'b01:   cnt_in = cnt_ff - RQ_CNT_W'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/tcce_back.sv -----
// back end: cursor, screen store and the sequencer for writes, scroll, clear and reads
// depends on tcce_pkg and tcce_ram

module tcce_back
   import tcce_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              work_valid,
   input  work_type          work,
   output back_ctrl_type     ctrl,
   input  logic              csr_valid,
   input  logic [ATTR_W-1:0] csr_data,
   input  logic              rsp_full,
   output logic              rsp_push,
   output rsp_type           rsp_entry
);

   state_type          state_ff, state_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [LIN_W-1:0]   cnt_ff, cnt_in;
   logic [ATTR_W-1:0]  attr_ff;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               hit_ff, hit_in;
   logic               glyph_ff, glyph_in;

   logic [LIN_W-1:0]   lin;
   logic [CELL_W-1:0]  blank_cell;
   logic               we, re;
   logic [ADDR_W-1:0]  waddr, raddr;
   logic [CELL_W-1:0]  wdata, rdata;

   assign lin        = LIN_W'(base_ff) + LIN_W'(col_ff);
   assign blank_cell = {attr_ff, CHAR_BLANK};

   tcce_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (re),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      base_in   = base_ff;
      cnt_in    = cnt_ff;
      char_in   = char_ff;
      hit_in    = hit_ff;
      glyph_in  = glyph_ff;
      we        = 1'b0;
      waddr     = '0;
      wdata     = '0;
      re        = 1'b0;
      raddr     = '0;
      ctrl.take = 1'b0;
      ctrl.busy = (state_ff == ST_INIT);
      rsp_push  = 1'b0;

      case (state_ff)
         ST_INIT: begin
            we    = 1'b1;
            waddr = ADDR_W'(cnt_ff);
            wdata = {RESET_ATTR, CHAR_BLANK};
            if (cnt_ff == LIN_W'(CELL_COUNT - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + LIN_W'(1);
            end
         end

         ST_IDLE: begin
            if (work_valid && !rsp_full) begin
               ctrl.take = 1'b1;
               state_in  = ST_DONE;
               hit_in    = 1'b0;
               case (work.op)
                  OP_LEFT: begin
                     if (col_ff != '0) begin
                        col_in = col_ff - COL_W'(1);
                     end else if (row_ff != '0) begin
                        row_in  = row_ff - ROW_W'(1);
                        base_in = base_ff - ADDR_W'(COLUMNS);
                        col_in  = COL_W'(COLUMNS - 1);
                     end
                  end
                  OP_RIGHT: begin
                     if (col_ff < COL_W'(COLUMNS - 1)) begin
                        col_in = col_ff + COL_W'(1);
                     end else if (row_ff < ROW_W'(ROWS - 1)) begin
                        row_in  = row_ff + ROW_W'(1);
                        base_in = base_ff + ADDR_W'(COLUMNS);
                        col_in  = '0;
                     end
                  end
                  OP_NEWLINE: begin
                     col_in = '0;
                     if (row_ff < ROW_W'(ROWS - 1)) begin
                        row_in  = row_ff + ROW_W'(1);
                        base_in = base_ff + ADDR_W'(COLUMNS);
                     end else begin
                        glyph_in = 1'b0;
                        cnt_in   = '0;
                        state_in = ST_SCROLL;
                     end
                  end
                  OP_BACKSPACE: begin
                     // the cell before the cursor, nothing at the origin
                     if (lin != '0) begin
                        we    = 1'b1;
                        waddr = ADDR_W'(lin - LIN_W'(1));
                        wdata = blank_cell;
                        if (col_ff != '0) begin
                           col_in = col_ff - COL_W'(1);
                        end else begin
                           row_in  = row_ff - ROW_W'(1);
                           base_in = base_ff - ADDR_W'(COLUMNS);
                           col_in  = COL_W'(COLUMNS - 1);
                        end
                     end
                  end
                  OP_GLYPH: begin
                     if (col_ff < COL_W'(COLUMNS)) begin
                        we     = 1'b1;
                        waddr  = ADDR_W'(lin);
                        wdata  = {attr_ff, work.char_code};
                        col_in = col_ff + COL_W'(1);
                     end else if (row_ff < ROW_W'(ROWS - 1)) begin
                        // deferred wrap: lin already points at the next row start
                        we      = 1'b1;
                        waddr   = ADDR_W'(lin);
                        wdata   = {attr_ff, work.char_code};
                        row_in  = row_ff + ROW_W'(1);
                        base_in = base_ff + ADDR_W'(COLUMNS);
                        col_in  = COL_W'(1);
                     end else begin
                        col_in   = '0;
                        char_in  = work.char_code;
                        glyph_in = 1'b1;
                        cnt_in   = '0;
                        state_in = ST_SCROLL;
                     end
                  end
                  OP_CLEAR: begin
                     row_in   = '0;
                     col_in   = '0;
                     base_in  = '0;
                     cnt_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  OP_READ: begin
                     if (work.cell_addr < CELL_COUNT) begin
                        re     = 1'b1;
                        raddr  = ADDR_W'(work.cell_addr);
                        hit_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_CLEAR: begin
            we    = 1'b1;
            waddr = ADDR_W'(cnt_ff);
            wdata = blank_cell;
            if (cnt_ff == LIN_W'(CELL_COUNT - 1)) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + LIN_W'(1);
            end
         end

         ST_SCROLL: begin
            // read one row ahead, write one cell behind
            if (cnt_ff < LIN_W'(MOVE_COUNT)) begin
               re    = 1'b1;
               raddr = ADDR_W'(cnt_ff + LIN_W'(COLUMNS));
            end
            if (cnt_ff != '0) begin
               we    = 1'b1;
               waddr = ADDR_W'(cnt_ff - LIN_W'(1));
               wdata = (cnt_ff <= LIN_W'(MOVE_COUNT)) ? rdata : blank_cell;
            end
            if (cnt_ff == LIN_W'(CELL_COUNT)) begin
               cnt_in   = '0;
               state_in = glyph_ff ? ST_GLYPH : ST_DONE;
            end else begin
               cnt_in = cnt_ff + LIN_W'(1);
            end
         end

         ST_GLYPH: begin
            we       = 1'b1;
            waddr    = ADDR_W'(lin);
            wdata    = {attr_ff, char_ff};
            col_in   = col_ff + COL_W'(1);
            state_in = ST_DONE;
         end

         ST_DONE: begin
            rsp_push = 1'b1;
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_entry.cursor_pos = POS_W'(lin);
   assign rsp_entry.cell_data  = hit_ff ? rdata : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         row_ff   <= '0;
         col_ff   <= '0;
         base_ff  <= '0;
         cnt_ff   <= '0;
         attr_ff  <= RESET_ATTR;
         hit_ff   <= 1'b0;
         glyph_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         base_ff  <= base_in;
         cnt_ff   <= cnt_in;
         hit_ff   <= hit_in;
         glyph_ff <= glyph_in;
         if (csr_valid) begin
            attr_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
   end

endmodule

// ----- rtl/text_console_character_engine.sv -----
// every command yields one result; the back end takes the next command only after
//   pushing the result of the last one
// a newline on the bottom row or a glyph past its end scrolls the screen; clear sweeps every cell
// reset: synchronous; afterwards a clearing pass fills the
//   screen with blanks while req_full stays high, csr writes are taken throughout
// depends on tcce_pkg, tcce_front, tcce_back, tcce_rsp_fifo

module text_console_character_engine
   import tcce_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_push,
   input  req_type           req_data,
   output logic              req_full,
   // result channel
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output rsp_type           rsp_data,
   // text attribute register write
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [ATTR_W-1:0] csr_data
);

   // front to back: classified command at the head of the command queue
   logic          work_valid;
   work_type      work;
   back_ctrl_type ctrl;

   // back to result queue
   logic          rsp_push;
   rsp_type       rsp_entry;
   logic          rsp_full;

   // the attribute register is a plain flop, writes never stall
   assign csr_ready = 1'b1;

   // front end: decode put character codes into operations, queue two deep
   tcce_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_data   (req_data),
      .req_full   (req_full),
      .ctrl       (ctrl),
      .work_valid (work_valid),
      .work       (work)
   );

   // back end: one command at a time, cell store sweeps for scroll and clear
   tcce_back u_back (
      .clock      (clock),
      .reset      (reset),
      .work_valid (work_valid),
      .work       (work),
      .ctrl       (ctrl),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_entry  (rsp_entry)
   );

   // result queue decouples the back end from a stalled consumer
   tcce_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_entry),
      .full      (rsp_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/tcce_checker.sv -----
// port level checks of the text console character engine, bound to the top level
// depends on tcce_pkg and text_console_character_engine

module tcce_port_checks
   import tcce_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);

   // a waiting result holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("result changed or vanished before pop");

   // the clearing pass follows every reset
   a_init_busy: assert property (@(posedge clock)
      reset |=> req_full)
      else $error("request accepted during the clearing pass");

   // the cursor never leaves the screen plus the deferred wrap position
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (int'(rsp_data.cursor_pos) <= CELL_COUNT))
      else $error("cursor position beyond the screen");

   // no result appears in the cycle right after reset
   a_no_early_rsp: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result present right after reset");

endmodule

bind text_console_character_engine tcce_port_checks u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

// ----- sim/tcce_checker.sv -----
// scoreboard for the text console character engine: watches the three channels,
// keeps its own screen image, cursor and attribute, and compares every result
// depends on tcce_pkg
`timescale 1ns / 1ps

module tcce_checker
   import tcce_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  req_type           req_data,
   input  logic              req_full,
   input  logic              rsp_empty,
   input  logic              rsp_pop,
   input  rsp_type           rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [ATTR_W-1:0] csr_data,
   output int                error_count,
   output int                pending,
   output int                scroll_count
);

   logic [CELL_W-1:0] screen_image [CELL_COUNT];
   int                cur_row;
   int                cur_col;
   logic [ATTR_W-1:0] attr_now;
   rsp_type           due_results [$];

   initial begin
      error_count  = 0;
      scroll_count = 0;
      pending      = 0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= 40)
         $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
   endtask

   task automatic fill_screen(input logic [ATTR_W-1:0] attr);
      for (int i = 0; i < CELL_COUNT; i++)
         screen_image[i] = {attr, CHAR_BLANK};
   endtask

   // column 0 of the next row, scrolling up at the bottom
   task automatic advance_line();
      cur_col = 0;
      cur_row++;
      if (cur_row >= ROWS) begin
         cur_row = ROWS - 1;
         for (int i = 0; i < MOVE_COUNT; i++)
            screen_image[i] = screen_image[i + COLUMNS];
         for (int i = MOVE_COUNT; i < CELL_COUNT; i++)
            screen_image[i] = {attr_now, CHAR_BLANK};
         scroll_count++;
      end
   endtask

   // false at the origin
   function automatic bit step_back();
      if (cur_col > 0) begin
         cur_col--;
      end else if (cur_row > 0) begin
         cur_row--;
         cur_col = COLUMNS - 1;
      end else begin
         return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic run_console_command(input req_type r, output rsp_type want);
      logic [CELL_W-1:0] data;
      data = '0;
      case (r.cmd)
         CMD_PUT: begin
            case (r.char_code)
               CHAR_LEFT: void'(step_back());
               CHAR_RIGHT: begin
                  if (cur_col < COLUMNS - 1) begin
                     cur_col++;
                  end else if (cur_row < ROWS - 1) begin
                     cur_row++;
                     cur_col = 0;
                  end
               end
               CHAR_NEWLINE: advance_line();
               CHAR_BACKSPACE: begin
                  if (step_back())
                     screen_image[cur_row * COLUMNS + cur_col] = {attr_now, CHAR_BLANK};
               end
               default: begin
                  if (cur_col >= COLUMNS)
                     advance_line();
                  screen_image[cur_row * COLUMNS + cur_col] = {attr_now, r.char_code};
                  cur_col++;
               end
            endcase
         end
         CMD_CLEAR: begin
            fill_screen(attr_now);
            cur_row = 0;
            cur_col = 0;
         end
         CMD_READ: begin
            if (r.cell_addr < CELL_COUNT)
               data = screen_image[r.cell_addr];
         end
         default: ;
      endcase
      want.cursor_pos = POS_W'(cur_row * COLUMNS + cur_col);
      want.cell_data  = data;
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type oldest;
      if (reset) begin
         attr_now = RESET_ATTR;
         cur_row  = 0;
         cur_col  = 0;
         fill_screen(RESET_ATTR);
         due_results.delete();
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready)
            attr_now = csr_data;
         if (rsp_pop && !rsp_empty) begin
            if (due_results.size() == 0) begin
               report_mismatch("result with nothing expected, cursor_pos",
                               int'(rsp_data.cursor_pos), 0);
            end else begin
               oldest = due_results.pop_front();
               if (rsp_data.cursor_pos !== oldest.cursor_pos)
                  report_mismatch("cursor_pos", int'(rsp_data.cursor_pos),
                                  int'(oldest.cursor_pos));
               if (rsp_data.cell_data !== oldest.cell_data)
                  report_mismatch("cell_data", int'(rsp_data.cell_data),
                                  int'(oldest.cell_data));
            end
         end
         if (req_push && !req_full) begin
            run_console_command(req_data, want);
            due_results.push_back(want);
         end
         pending <= due_results.size();
      end
   end

endmodule

// ----- sim/tb_text_console_character_engine.sv -----
// testbench top for the text console character engine: clock, reset, command
// stimulus, result draining and the verdict; checking lives in tcce_checker
// depends on tcce_pkg, tcce_checker and the engine rtl
`timescale 1ns / 1ps

module tb_text_console_character_engine;
   import tcce_pkg::*;

   // the one command code the engine leaves undefined
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // longest quiet stretch allowed: it must outlast a clear or scroll, the long
   // receiver hold-off, and the further such commands that may be queued
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 400;
   localparam int PHASE_ITEMS    = 200;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_push  = 1'b0;
   req_type           req_data  = '0;
   logic              req_full;
   logic              rsp_empty;
   logic              rsp_pop   = 1'b0;
   rsp_type           rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [ATTR_W-1:0] csr_data  = '0;

   int error_count;
   int pending;
   int scroll_count;

   // sender bookkeeping
   int burst_left  = 0;
   int sent_count  = 0;
   int read_count  = 0;
   int clear_count = 0;
   int attr_writes = 0;

   // receiver bookkeeping
   int rx_mode      = 0;
   int rx_mode_left = 0;
   int rx_tick      = 0;
   int popped_total = 0;
   int next_hold_at = 300;
   int hold_left    = 0;

   int quiet_cycles = 0;

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   text_console_character_engine i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   tcce_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_data     (req_data),
      .req_full     (req_full),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_data     (rsp_data),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .error_count  (error_count),
      .pending      (pending),
      .scroll_count (scroll_count)
   );

   // one command transaction; the sender works in bursts with random gaps,
   // a gap of zero keeps push high across bursts
   task automatic issue(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                        input logic [10:0] addr);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap != 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         // now and then a long burst with no idling at all
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      req_push           <= 1'b1;
      req_data.cmd       <= cmd;
      req_data.char_code <= ch;
      req_data.cell_addr <= addr;
      do @(posedge clock); while (req_full);
      burst_left--;
      sent_count++;
      if (cmd == CMD_READ)
         read_count++;
      if (cmd == CMD_CLEAR)
         clear_count++;
   endtask

   // stop offering and wait until every expected result has been taken;
   // the first edge lets the checker count the last accepted command
   task automatic drain();
      req_push  <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending != 0);
   endtask

   // only called with the engine idle
   task automatic set_attribute(input logic [ATTR_W-1:0] attr);
      csr_data  <= attr;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      attr_writes++;
   endtask

   // receiver: stall pattern that changes mode now and then, plus a long
   // hold-off every few hundred results so the engine backs up to req_full
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty)
            popped_total++;
         rx_tick++;
         if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(20, 150);
         end else begin
            rx_mode_left--;
         end
         if (hold_left == 0 && popped_total >= next_hold_at) begin
            hold_left     = HOLD_CYCLES;
            next_hold_at += 400;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            case (rx_mode)
               0: rsp_pop <= 1'b1;                          // no stalls
               1: rsp_pop <= 1'($urandom_range(0, 1));      // coin flip
               2: rsp_pop <= (rx_tick % 4 == 0);            // one pop in four
               default: rsp_pop <= ($urandom_range(0, 9) == 0);   // mostly stalled
            endcase
         end
      end
   end

   // watchdog: cycles in which no transaction moves on any channel
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                  quiet_cycles, pending);
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int                phase;
      int                sel;
      int                run;
      logic [CHAR_W-1:0] ch;
      logic [CHAR_W-1:0] moves [3];

      moves[0] = CHAR_LEFT;
      moves[1] = CHAR_RIGHT;
      moves[2] = CHAR_BACKSPACE;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // the engine blanks the screen after reset with req_full high
      @(posedge clock);
      do @(posedge clock); while (req_full);

      // directed part, reset attribute
      issue(CMD_READ, 8'h00, 11'd0);
      issue(CMD_READ, 8'hFF, 11'(CELL_COUNT - 1));
      issue(CMD_READ, 8'h00, 11'(CELL_COUNT));        // just past the screen
      issue(CMD_READ, 8'hFF, 11'h7FF);                // top of the address range
      issue(CMD_PUT, CHAR_LEFT, 11'h7FF);             // cursor left at the origin
      issue(CMD_PUT, CHAR_BACKSPACE, 11'd0);          // backspace at the origin
      issue(CMD_PUT, 8'h00, 11'd0);                   // lowest byte as a glyph
      issue(CMD_PUT, 8'hFF, 11'h7FF);                 // highest byte as a glyph
      issue(CMD_PUT, 8'h41, 11'd0);
      issue(CMD_PUT, CHAR_RIGHT, 11'd0);
      issue(CMD_PUT, CHAR_LEFT, 11'd0);
      issue(CMD_PUT, CHAR_BACKSPACE, 11'd0);          // erases the 'A'
      issue(CMD_PUT, CHAR_NEWLINE, 11'd0);
      issue(CMD_PUT, CHAR_BACKSPACE, 11'd0);          // back across the row boundary
      issue(CMD_READ, 8'h00, 11'(COLUMNS - 1));
      issue(CMD_READ, 8'h00, 11'd1);
      issue(CMD_UNUSED, 8'hFF, 11'h7FF);              // undefined command
      drain();

      // all-zero attribute, then clear and look at the result
      set_attribute(8'h00);
      issue(CMD_PUT, 8'h5A, 11'd0);
      issue(CMD_READ, 8'h00, 11'd0);
      issue(CMD_CLEAR, 8'h00, 11'd0);
      issue(CMD_READ, 8'h00, 11'd2);
      issue(CMD_PUT, CHAR_RIGHT, 11'd0);

      // random part in phases, each under its own attribute
      for (phase = 0; phase < 4; phase++) begin
         // sender pauses until every result is back before the register write
         drain();
         case (phase)
            0:       set_attribute(8'hFF);
            1:       set_attribute(8'($urandom_range(1, 254)));
            2:       set_attribute(8'h1E);
            default: set_attribute(8'($urandom));
         endcase
         while (sent_count < 25 + (phase + 1) * PHASE_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
               // a line of text; full-width lines exercise the deferred wrap
               run = ($urandom_range(0, 9) < 3) ? COLUMNS + $urandom_range(0, 2) - 1
                                                : $urandom_range(1, 40);
               repeat (run) begin
                  ch = ($urandom_range(0, 19) == 0) ? 8'($urandom)
                                                    : 8'($urandom_range(8'h20, 8'h7E));
                  issue(CMD_PUT, ch, 11'($urandom));
               end
               if ($urandom_range(0, 1) == 0)
                  issue(CMD_PUT, CHAR_NEWLINE, 11'($urandom));
            end else if (sel < 60) begin
               // cursor moves and erases
               repeat ($urandom_range(1, 6))
                  issue(CMD_PUT, moves[$urandom_range(0, 2)], 11'($urandom));
            end else if (sel < 70) begin
               repeat ($urandom_range(1, 4))
                  issue(CMD_PUT, CHAR_NEWLINE, 11'($urandom));
            end else if (sel < 85) begin
               // reads: whole screen, the last row, the full address range
               repeat ($urandom_range(1, 4)) begin
                  case ($urandom_range(0, 2))
                     0:       issue(CMD_READ, 8'($urandom),
                                    11'($urandom_range(0, CELL_COUNT - 1)));
                     1:       issue(CMD_READ, 8'($urandom),
                                    11'($urandom_range(MOVE_COUNT, CELL_COUNT - 1)));
                     default: issue(CMD_READ, 8'($urandom), 11'($urandom));
                  endcase
               end
            end else if (sel < 87) begin
               issue(CMD_CLEAR, 8'($urandom), 11'($urandom));
            end else begin
               // noise: any command code, any byte, any address
               issue(2'($urandom), 8'($urandom), 11'($urandom));
            end
         end
      end

      // let everything come back, then watch for stray results for about
      // one clear or scroll
      drain();
      repeat (CELL_COUNT + 100) @(posedge clock);

      $display("covered %0d commands (%0d reads, %0d clears), %0d attribute writes,",
               sent_count, read_count, clear_count, attr_writes);
      $display("%0d scrolls, %0d results checked, %0d mismatches",
               scroll_count, popped_total, error_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
